// ----- rtl/framed_command_receiver_crc16_top_defines.svh -----
// Assertion macros shared by the receiver modules.
`ifndef FRAMED_COMMAND_RECEIVER_CRC16_TOP_DEFINES_SVH
`define FRAMED_COMMAND_RECEIVER_CRC16_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCR_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FCR_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/fcr_pkg.sv -----
package fcr_pkg;

	// Frame framing constants
	localparam logic [7:0] SYNC_FIRST    = 8'hAA;
	localparam logic [7:0] SYNC_SECOND   = 8'h55;
	localparam logic [7:0] FRAME_END     = 8'h0D;
	localparam logic [7:0] VALUE_CMD_MIN = 8'd9;
	localparam logic [7:0] LEN_SLACK     = 8'd3;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'hA001;
	localparam int unsigned MAX_FRAME_DEF = 64;
	localparam int unsigned COUNT_W       = 7;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CRC_ERR  = 2'd1,
		ST_OVERFLOW = 2'd2
	} fcr_status_t;

	typedef struct packed {
		fcr_status_t status;
		logic [7:0]  command;
		logic [7:0]  subfunction;
		logic [31:0] set_value;
		logic [7:0]  frame_length;
	} fcr_result_t;

	// Reflected Modbus CRC-16, one byte folded in
	function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/fcr_frame.sv -----
`include "framed_command_receiver_crc16_top_defines.svh"

module fcr_frame import fcr_pkg::*; #(
	parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [7:0]  rx,
	output logic        res_valid,
	output fcr_result_t res
);

	localparam logic [COUNT_W-1:0] MaxFrameC = COUNT_W'(MAX_FRAME);

	logic                in_frame_q, in_frame_d;
	logic [7:0]          prev_q, prev_d;
	logic [COUNT_W-1:0]  count_q, count_d;
	logic [7:0]          len_q, len_d;
	logic [7:0]          cmd_q, cmd_d;
	logic [31:0]         val_q, val_d;
	logic [15:0]         crc_q, crc_d;
	logic [7:0]          lag_q [3];
	logic [7:0]          lag_d [3];
	logic [7:0]          n;
	logic                frame_end;
	logic                crc_match;

	assign n = {1'b0, count_q} + 8'd1;

	// Per-byte frame state update and result decision
	always_comb begin
		in_frame_d = in_frame_q;
		prev_d     = prev_q;
		count_d    = count_q;
		len_d      = len_q;
		cmd_d      = cmd_q;
		val_d      = val_q;
		crc_d      = crc_q;
		lag_d      = lag_q;
		frame_end  = 1'b0;
		crc_match  = 1'b0;
		res_valid  = 1'b0;
		res        = '{status: ST_OK, command: 8'd0, subfunction: 8'd0,
		               set_value: 32'd0, frame_length: len_q};

		if (!in_frame_q) begin
			// sync hunt
			if (prev_q == SYNC_FIRST && rx == SYNC_SECOND) begin
				in_frame_d = 1'b1;
				prev_d     = 8'd0;
				count_d    = '0;
				len_d      = 8'd0;
				cmd_d      = 8'd0;
				val_d      = 32'd0;
				crc_d      = CRC_INIT;
				lag_d      = '{default: 8'd0};
			end else begin
				prev_d = rx;
			end
		end else if (count_q >= MaxFrameC) begin
			// overflow: drop byte, report, go back to hunting
			res_valid    = 1'b1;
			res.status   = ST_OVERFLOW;
			in_frame_d   = 1'b0;
			prev_d       = 8'd0;
			count_d      = '0;
		end else begin
			case (count_q)
				COUNT_W'(0): len_d = rx;
				COUNT_W'(2): cmd_d = rx;
				COUNT_W'(3): val_d[7:0]   = rx;
				COUNT_W'(4): val_d[15:8]  = rx;
				COUNT_W'(5): val_d[23:16] = rx;
				COUNT_W'(6): val_d[31:24] = rx;
				default: ;
			endcase

			// CRC runs three bytes behind the newest
			if (count_q >= COUNT_W'(3)) begin
				crc_d = crc16_fold(crc_q, lag_q[2]);
			end

			frame_end = (rx == FRAME_END) && (n >= 8'd4) && ((n + LEN_SLACK) == len_d);
			crc_match = (lag_q[1] == crc_d[15:8]) && (lag_q[0] == crc_d[7:0]);

			if (frame_end) begin
				res_valid        = 1'b1;
				res.frame_length = len_d;
				if (crc_match) begin
					res.status      = ST_OK;
					res.command     = cmd_d;
					res.subfunction = val_d[31:24];
					res.set_value   = (cmd_d >= VALUE_CMD_MIN) ? val_d : 32'd0;
				end else begin
					res.status = ST_CRC_ERR;
				end
				in_frame_d = 1'b0;
				prev_d     = 8'd0;
				count_d    = '0;
			end else begin
				lag_d[2] = lag_q[1];
				lag_d[1] = lag_q[0];
				lag_d[0] = rx;
				count_d  = n[COUNT_W-1:0];
			end
		end

		if (!en) begin
			res_valid = 1'b0;
		end
	end

	// Frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			prev_q     <= 8'd0;
			count_q    <= '0;
			len_q      <= 8'd0;
			cmd_q      <= 8'd0;
			val_q      <= 32'd0;
			crc_q      <= CRC_INIT;
			lag_q      <= '{default: 8'd0};
		end else if (en) begin
			in_frame_q <= in_frame_d;
			prev_q     <= prev_d;
			count_q    <= count_d;
			len_q      <= len_d;
			cmd_q      <= cmd_d;
			val_q      <= val_d;
			crc_q      <= crc_d;
			lag_q      <= lag_d;
		end
	end

	`FCR_ASSERT_IMP(a_res_in_frame, clk, arst_n, res_valid, in_frame_q && en,
		"result raised outside a frame")
	`FCR_ASSERT_NXT(a_res_leaves, clk, arst_n, res_valid, !in_frame_q,
		"frame not left after a result")
	`FCR_ASSERT_NXT(a_cnt_step, clk, arst_n, en && in_frame_q && !res_valid,
		in_frame_q && (count_q == $past(count_q) + COUNT_W'(1)),
		"byte count did not advance by one")

endmodule

// ----- rtl/fcr_out_buf.sv -----
`include "framed_command_receiver_crc16_top_defines.svh"

module fcr_out_buf import fcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  fcr_result_t push_res,
	output logic        room,
	output logic        m_valid,
	input  logic        m_ready,
	output fcr_result_t m_res
);

	logic        out_valid_q;
	logic        skid_valid_q;
	fcr_result_t out_q;
	fcr_result_t skid_q;
	logic        pop;
	logic        load_out;

	assign pop      = out_valid_q && m_ready;
	assign load_out = !out_valid_q || pop;
	assign room     = !skid_valid_q;
	assign m_valid  = out_valid_q;
	assign m_res    = out_q;

	// Occupancy flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= skid_valid_q && push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Result payload: output register fed from skid first
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= skid_valid_q ? skid_q : push_res;
			if (skid_valid_q && push) begin
				skid_q <= push_res;
			end
		end else if (push) begin
			skid_q <= push_res;
		end
	end

	`FCR_ASSERT_IMP(a_skid_order, clk, arst_n, skid_valid_q, out_valid_q,
		"skid entry held while output register empty")
	`FCR_ASSERT_IMP(a_no_overrun, clk, arst_n, push, !skid_valid_q,
		"result pushed into a full buffer")

endmodule

// ----- rtl/framed_command_receiver_crc16_top.sv -----
// Framed command receiver with Modbus CRC-16 check.
// s_axis carries one received serial byte per request in s_axis_tdata[7:0].
// The block hunts for the sync pair 0xAA 0x55, collects the frame, checks
// the CRC and sends at most one result request per frame on m_axis:
// tuser holds the status (ok, crc mismatch, overflow), tdata the command,
// subfunction, 32-bit value and length byte.
// A byte is registered in the input register; its result is decided
// combinationally from there and is registered in the result buffer when
// that byte leaves the input register.
// Throughput: one byte per cycle while s_axis_tready is high; the CRC byte
// fold and frame compare are combinational between input and result registers.
// A two-entry result buffer (output register plus skid) lets input keep
// flowing while a result waits. Once both entries are held, the input
// register still takes one more byte if it is empty; s_axis_tready then
// stays low until m_axis takes a result, and is high again right after that edge.
// Reset (arst_n low) returns the block to sync hunting with empty buffers.
module framed_command_receiver_crc16_top import fcr_pkg::*; #(
	parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // [7:0] command, [15:8] subfunction,
	                                    // [47:16] set_value, [55:48] frame_length
	output logic [1:0]  m_axis_tuser    // [1:0] status
);

	logic        valid_s1;
	logic [7:0]  rx_s1;
	logic        room;
	logic        advance;
	logic        accept;
	logic        res_valid;
	fcr_result_t res;
	fcr_result_t m_res;

	assign advance       = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rx_s1 <= s_axis_tdata;
		end
	end

	fcr_frame #(
		.MAX_FRAME(MAX_FRAME)
	) u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.rx       (rx_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	fcr_out_buf u_out_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_valid),
		.push_res(res),
		.room    (room),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_res   (m_res)
	);

	assign m_axis_tdata = {m_res.frame_length, m_res.set_value, m_res.subfunction,
	                       m_res.command};
	assign m_axis_tuser = m_res.status;

endmodule

// ----- sim/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fcr_pkg::*;

	localparam int ITEM_TARGET = 1500;
	localparam int HOLD_CYCLES = 300;
	localparam int DIR_ROWS    = 20;

	localparam fcr_result_t NONE_RES = '{ST_OK, 8'h00, 8'h00, 32'h0, 8'h00};

	// Directed rows: the CRC kinds are filled from the bytes of the frame so far
	typedef enum logic [1:0] {
		DB_BYTE,
		DB_LEN,
		DB_CRC_HI,
		DB_CRC_LO
	} dir_kind_t;

	typedef struct {
		dir_kind_t   kind;
		logic [7:0]  value;
		bit          typed;
		fcr_result_t res;
	} dir_row_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic [7:0]  s_axis_tdata  = 8'h00;
	logic        m_axis_tready = 1'b0;
	logic        s_axis_tready;
	logic        m_axis_tvalid;
	logic [55:0] m_axis_tdata;   // [7:0] command, [15:8] subfunction,
	                             // [47:16] set_value, [55:48] frame_length
	logic [1:0]  m_axis_tuser;   // [1:0] status

	// Receiver model state
	bit          rx_in_frame;
	logic [7:0]  rx_prev;
	logic [6:0]  rx_count;
	logic [7:0]  rx_len;
	logic [7:0]  rx_cmd;
	logic [31:0] rx_value;
	logic [15:0] rx_crc;
	logic [7:0]  rx_lag [3];

	fcr_result_t pending_results[$];
	dir_row_t    dir_rows [DIR_ROWS];

	int bytes_sent;
	int results_seen;
	int ok_frames;
	int crc_errors;
	int overflows;
	int fail_count;
	int send_idle_pct;
	int stall_pct;
	bit hold_done;

	always #5 clk = ~clk;

	framed_command_receiver_crc16_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Reflected Modbus CRC-16, one byte
	function automatic logic [15:0] modbus_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		repeat (8) begin
			c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		end
		return c;
	endfunction

	// Advance the receiver model by one byte; returns 1 when a frame result is due
	function automatic bit frame_step(input logic [7:0] b, output fcr_result_t res);
		int unsigned k;
		res = NONE_RES;
		if (!rx_in_frame) begin
			if (rx_prev == SYNC_FIRST && b == SYNC_SECOND) begin
				rx_in_frame = 1'b1;
				rx_prev     = 8'h00;
				rx_count    = '0;
				rx_len      = 8'h00;
				rx_cmd      = 8'h00;
				rx_value    = 32'h0;
				rx_crc      = CRC_INIT;
				rx_lag[0]   = 8'h00;
				rx_lag[1]   = 8'h00;
				rx_lag[2]   = 8'h00;
			end else begin
				rx_prev = b;
			end
			return 1'b0;
		end
		k = rx_count;
		// frame too long: byte dropped
		if (k >= MAX_FRAME_DEF) begin
			res.status       = ST_OVERFLOW;
			res.frame_length = rx_len;
			rx_in_frame      = 1'b0;
			rx_prev          = 8'h00;
			rx_count         = '0;
			return 1'b1;
		end
		if (k == 0) begin
			rx_len = b;
		end else if (k == 2) begin
			rx_cmd = b;
		end else if (k >= 3 && k <= 6) begin
			rx_value[8*(k-3) +: 8] = b;
		end
		if (k >= 3) begin
			rx_crc = modbus_fold(rx_crc, rx_lag[2]);
		end
		// closing CR with a matching length
		if (b == FRAME_END && k + 1 >= 4 && k + 1 + LEN_SLACK == rx_len) begin
			if (rx_lag[1] == rx_crc[15:8] && rx_lag[0] == rx_crc[7:0]) begin
				res.status      = ST_OK;
				res.command     = rx_cmd;
				res.subfunction = rx_value[31:24];
				res.set_value   = (rx_cmd >= VALUE_CMD_MIN) ? rx_value : 32'h0;
			end else begin
				res.status = ST_CRC_ERR;
			end
			res.frame_length = rx_len;
			rx_in_frame      = 1'b0;
			rx_prev          = 8'h00;
			rx_count         = '0;
			return 1'b1;
		end
		rx_lag[2] = rx_lag[1];
		rx_lag[1] = rx_lag[0];
		rx_lag[0] = b;
		rx_count  = 7'(k + 1);
		return 1'b0;
	endfunction

	// Offer one byte; called and returns at a falling edge
	task automatic send_byte(input logic [7:0] b, input bit typed, input fcr_result_t typed_res);
		fcr_result_t res;
		bit          got;
		int          ph;
		ph = bytes_sent * 4 / ITEM_TARGET;
		case (ph)
			0:       begin send_idle_pct = 0;  stall_pct = 0;  end
			1:       begin send_idle_pct = 54; stall_pct = 0;  end
			2:       begin send_idle_pct = 0;  stall_pct = 54; end
			default: begin send_idle_pct = 22; stall_pct = 22; end
		endcase
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		got = frame_step(b, res);
		if (typed) begin
			pending_results.push_back(typed_res);
		end else if (got) begin
			pending_results.push_back(res);
		end
		bytes_sent++;
		@(negedge clk);
	endtask

	// One random sequence: mostly well-formed frames, some overflow, broken or noise
	task automatic send_random_frame();
		logic [7:0]  body[$];
		logic [7:0]  b;
		logic [15:0] crc;
		int unsigned sel;
		int unsigned n;
		sel = $urandom_range(99);
		repeat ($urandom_range(2)) body.push_back(8'($urandom));
		if (sel < 80) begin
			n = ($urandom_range(9) != 0) ? $urandom_range(14, 4) : $urandom_range(MAX_FRAME_DEF, 4);
			body.push_back(SYNC_FIRST);
			body.push_back(SYNC_SECOND);
			crc = CRC_INIT;
			for (int unsigned i = 0; i <= n - 4; i++) begin
				if (i == 0) begin
					b = 8'(n + 3);
				end else if (i == 2) begin
					b = $urandom_range(1) ? 8'($urandom_range(8)) : 8'($urandom);
				end else begin
					b = 8'($urandom);
				end
				crc = modbus_fold(crc, b);
				body.push_back(b);
			end
			// corrupt one CRC bit now and then
			if ($urandom_range(99) < 15) begin
				crc = crc ^ 16'(1 << $urandom_range(15));
			end
			body.push_back(crc[15:8]);
			body.push_back(crc[7:0]);
			body.push_back(FRAME_END);
		end else if (sel < 84) begin
			// length that can never close: runs into overflow
			body.push_back(SYNC_FIRST);
			body.push_back(SYNC_SECOND);
			body.push_back(8'($urandom_range(255, 68)));
			repeat (MAX_FRAME_DEF) body.push_back(8'($urandom));
		end else if (sel < 90) begin
			// truncated frame, later bytes land inside it
			body.push_back(SYNC_FIRST);
			body.push_back(SYNC_SECOND);
			repeat ($urandom_range(7, 1)) body.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(6, 1)) begin
				body.push_back($urandom_range(3) == 0 ? SYNC_FIRST : 8'($urandom));
			end
		end
		foreach (body[i]) send_byte(body[i], 1'b0, NONE_RES);
	endtask

	// Result checker
	always @(posedge clk) begin : check_result
		fcr_result_t exp_res;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			case (m_axis_tuser)
				ST_OK:      ok_frames++;
				ST_CRC_ERR: crc_errors++;
				default:    overflows++;
			endcase
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d data %014h", m_axis_tuser, m_axis_tdata);
				fail_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (m_axis_tuser !== exp_res.status) begin
					$error("status: expected %0d, got %0d", exp_res.status, m_axis_tuser);
					fail_count++;
				end
				if (m_axis_tdata[7:0] !== exp_res.command) begin
					$error("command: expected %02h, got %02h", exp_res.command,
						m_axis_tdata[7:0]);
					fail_count++;
				end
				if (m_axis_tdata[15:8] !== exp_res.subfunction) begin
					$error("subfunction: expected %02h, got %02h", exp_res.subfunction,
						m_axis_tdata[15:8]);
					fail_count++;
				end
				if (m_axis_tdata[47:16] !== exp_res.set_value) begin
					$error("set_value: expected %08h, got %08h", exp_res.set_value,
						m_axis_tdata[47:16]);
					fail_count++;
				end
				if (m_axis_tdata[55:48] !== exp_res.frame_length) begin
					$error("frame_length: expected %02h, got %02h", exp_res.frame_length,
						m_axis_tdata[55:48]);
					fail_count++;
				end
			end
		end
	end

	// Result side backpressure, with one long hold-off early on
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= 4) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [15:0] dir_crc;
		logic [7:0]  b;
		dir_rows = '{
			'{DB_BYTE,   8'h00, 1'b0, NONE_RES},
			// repeated sync first byte, then a 4-byte frame with a CR inside it
			'{DB_BYTE,   8'hAA, 1'b0, NONE_RES},
			'{DB_BYTE,   8'hAA, 1'b0, NONE_RES},
			'{DB_BYTE,   8'h55, 1'b0, NONE_RES},
			'{DB_LEN,    8'h07, 1'b0, NONE_RES},
			'{DB_BYTE,   8'h0D, 1'b0, NONE_RES},
			'{DB_BYTE,   8'h00, 1'b0, NONE_RES},
			'{DB_BYTE,   8'h0D, 1'b1, '{ST_CRC_ERR, 8'h00, 8'h00, 32'h0, 8'h07}},
			// good frame, all-ones command and value
			'{DB_BYTE,   8'hAA, 1'b0, NONE_RES},
			'{DB_BYTE,   8'h55, 1'b0, NONE_RES},
			'{DB_LEN,    8'h0D, 1'b0, NONE_RES},
			'{DB_BYTE,   8'h00, 1'b0, NONE_RES},
			'{DB_BYTE,   8'hFF, 1'b0, NONE_RES},
			'{DB_BYTE,   8'hFF, 1'b0, NONE_RES},
			'{DB_BYTE,   8'hFF, 1'b0, NONE_RES},
			'{DB_BYTE,   8'hFF, 1'b0, NONE_RES},
			'{DB_BYTE,   8'hFF, 1'b0, NONE_RES},
			'{DB_CRC_HI, 8'h00, 1'b0, NONE_RES},
			'{DB_CRC_LO, 8'h00, 1'b0, NONE_RES},
			'{DB_BYTE,   8'h0D, 1'b1, '{ST_OK, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'h0D}}
		};
		dir_crc = CRC_INIT;
		rx_in_frame = 1'b0;
		rx_prev     = 8'h00;
		rx_count    = '0;
		rx_len      = 8'h00;
		rx_cmd      = 8'h00;
		rx_value    = 32'h0;
		rx_crc      = CRC_INIT;
		rx_lag[0]   = 8'h00;
		rx_lag[1]   = 8'h00;
		rx_lag[2]   = 8'h00;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table
		for (int r = 0; r < DIR_ROWS; r++) begin
			case (dir_rows[r].kind)
				DB_LEN:    begin b = dir_rows[r].value; dir_crc = modbus_fold(CRC_INIT, b); end
				DB_CRC_HI: b = dir_crc[15:8];
				DB_CRC_LO: b = dir_crc[7:0];
				default:   begin b = dir_rows[r].value; dir_crc = modbus_fold(dir_crc, b); end
			endcase
			send_byte(b, dir_rows[r].typed, dir_rows[r].res);
		end

		// Random frames
		while (bytes_sent < ITEM_TARGET) send_random_frame();
		s_axis_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("tb: %0d bytes sent; results: %0d good frames, %0d crc mismatches, %0d overflows",
			bytes_sent, ok_frames, crc_errors, overflows);
		$display("tb: idle mixes none/sender/receiver/both, long result hold-off done: %0d",
			hold_done);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/fcr_pkg.sv
rtl/fcr_frame.sv
rtl/fcr_out_buf.sv
rtl/framed_command_receiver_crc16_top.sv
sim/tb.sv
